>>> src/fse_pkg.sv
// fse_pkg: shared types and constants for the format specifier expander.
// Payload structs, ASCII codes, controller/datapath command and status types.
// No dependencies.
package fse_pkg;

	typedef struct packed {
		logic [7:0]         mode;
		logic signed [31:0] arg_value;
	} fse_in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
		logic [3:0] char_count;
	} fse_out_t;

	// ASCII codes
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_I     = 8'h69;

	// Conversion geometry
	localparam int ARG_W      = 32;
	localparam int NUM_DIGITS = 10;
	localparam int BITCNT_W   = $clog2(ARG_W);
	localparam int DIGIT_IX_W = $clog2(NUM_DIGITS);

	// Specifier classes
	localparam logic [1:0] KIND_CHAR  = 2'd0;
	localparam logic [1:0] KIND_PCT   = 2'd1;
	localparam logic [1:0] KIND_DEC   = 2'd2;
	localparam logic [1:0] KIND_OTHER = 2'd3;

	// Character source select
	localparam logic [2:0] SEL_ARG   = 3'd0;
	localparam logic [2:0] SEL_PCT   = 3'd1;
	localparam logic [2:0] SEL_MODE  = 3'd2;
	localparam logic [2:0] SEL_MINUS = 3'd3;
	localparam logic [2:0] SEL_DIGIT = 3'd4;

	typedef struct packed {
		logic       load;   // capture a new item
		logic       shift;  // one double-dabble step
		logic       seek;   // point at the leading digit
		logic       emit;   // put one character on the result port
		logic [2:0] sel;    // character source
		logic       last;   // final character of the item
	} fse_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       neg;
		logic       conv_last;  // this shift is the final one
		logic       dig_last;   // pointer sits on the units digit
	} fse_status_t;

endpackage

>>> src/format_specifier_expander_unit.sv
// Format specifier expander: conversion character plus 32-bit argument in, printf text out.
// Output: 'c'/'%' transfer a single character, other unknown specifiers '%' and then the
// specifier itself; 'd'/'i' take 32 shift steps and a leading-digit seek, then one character
// per cycle (up to eleven characters).
// Throughput: one item at a time; busy drops in the cycle of the last transfer, so the next
// start overlaps it; results cannot be stalled. Reset: controller idle, strobe low.
module format_specifier_expander_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  fse_pkg::fse_in_t   item,
	output fse_pkg::fse_out_t  result,
	output logic               strobe
);

	// command and status between sequencer and datapath
	fse_pkg::fse_cmd_t    cmd;
	fse_pkg::fse_status_t status;

	// Sequencer: dispatch on the specifier class, run the 32 shift steps,
	// then walk the digit pointer from the leading digit down to units.
	fse_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath: magnitude and BCD registers, character mux and the
	// registered result port. Each emitted character is one transfer.
	fse_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result),
		.strobe (strobe)
	);

endmodule

>>> src/fse_datapath.sv
// fse_datapath: item registers, binary-to-BCD shifter, digit pointer and
// result register of the format specifier expander. Uses fse_pkg.
module fse_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fse_pkg::fse_in_t     item,
	input  fse_pkg::fse_cmd_t    cmd,
	output fse_pkg::fse_status_t status,
	output fse_pkg::fse_out_t    result,
	output logic                 strobe
);

	logic [7:0]                                mode_q;
	logic [7:0]                                low_q;
	logic [fse_pkg::ARG_W-1:0]                 mag_q;
	logic                                      neg_q;
	logic [fse_pkg::NUM_DIGITS-1:0][3:0]       bcd_q;
	logic [fse_pkg::NUM_DIGITS-1:0][3:0]       bcd_adj;
	logic [fse_pkg::NUM_DIGITS*4-1:0]          bcd_flat;
	logic [fse_pkg::BITCNT_W-1:0]              bitcnt_q;
	logic [fse_pkg::DIGIT_IX_W-1:0]            ptr_q;
	logic [fse_pkg::DIGIT_IX_W-1:0]            lead;
	logic [3:0]                                cnt_q;
	logic [7:0]                                ch;
	logic [1:0]                                kind;
	logic                                      strobe_q;
	fse_pkg::fse_out_t                         result_q;

	// Specifier class
	always_comb begin
		case (mode_q)
			fse_pkg::CH_C:             kind = fse_pkg::KIND_CHAR;
			fse_pkg::CH_PCT:           kind = fse_pkg::KIND_PCT;
			fse_pkg::CH_D, fse_pkg::CH_I: kind = fse_pkg::KIND_DEC;
			default:                   kind = fse_pkg::KIND_OTHER;
		endcase
	end

	assign status.kind      = kind;
	assign status.neg       = neg_q;
	assign status.conv_last = (bitcnt_q == fse_pkg::BITCNT_W'(fse_pkg::ARG_W - 1));
	assign status.dig_last  = (ptr_q == '0);

	// add-3 correction on every digit before the shift
	always_comb begin
		for (int i = 0; i < fse_pkg::NUM_DIGITS; i++) begin
			bcd_adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	assign bcd_flat = bcd_adj;

	// highest nonzero digit, units digit when the value is zero
	always_comb begin
		lead = '0;
		for (int i = 0; i < fse_pkg::NUM_DIGITS; i++) begin
			if (bcd_q[i] != 4'd0) lead = fse_pkg::DIGIT_IX_W'(i);
		end
	end

	always_comb begin
		case (cmd.sel)
			fse_pkg::SEL_ARG:   ch = low_q;
			fse_pkg::SEL_PCT:   ch = fse_pkg::CH_PCT;
			fse_pkg::SEL_MODE:  ch = mode_q;
			fse_pkg::SEL_MINUS: ch = fse_pkg::CH_MINUS;
			fse_pkg::SEL_DIGIT: ch = fse_pkg::CH_ZERO + {4'b0, bcd_q[ptr_q]};
			default:            ch = fse_pkg::CH_PCT;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= item.mode;
			low_q  <= item.arg_value[7:0];
			neg_q  <= item.arg_value[fse_pkg::ARG_W-1];
			mag_q  <= item.arg_value[fse_pkg::ARG_W-1] ?
				(fse_pkg::ARG_W)'(0) - item.arg_value : item.arg_value;
			bcd_q  <= '0;
		end else if (cmd.shift) begin
			bcd_q <= {bcd_flat[fse_pkg::NUM_DIGITS*4-2:0], mag_q[fse_pkg::ARG_W-1]};
			mag_q <= {mag_q[fse_pkg::ARG_W-2:0], 1'b0};
		end
		if (cmd.emit) begin
			result_q.out_char   <= ch;
			result_q.last       <= cmd.last;
			result_q.char_count <= cmd.last ? cnt_q + 4'd1 : 4'd0;
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitcnt_q <= '0;
			ptr_q    <= '0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
			if (cmd.load) begin
				bitcnt_q <= '0;
				cnt_q    <= '0;
			end else begin
				if (cmd.shift) bitcnt_q <= bitcnt_q + 1'b1;
				if (cmd.emit)  cnt_q    <= cnt_q + 4'd1;
			end
			if (cmd.seek) begin
				ptr_q <= lead;
			end else if (cmd.emit && cmd.sel == fse_pkg::SEL_DIGIT && ptr_q != '0) begin
				ptr_q <= ptr_q - 1'b1;
			end
		end
	end

	assign result = result_q;
	assign strobe = strobe_q;

endmodule

>>> src/fse_controller.sv
// fse_controller: sequencing state machine of the format specifier expander.
// Issues datapath commands from datapath status. Uses fse_pkg.
module fse_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  fse_pkg::fse_status_t status,
	output fse_pkg::fse_cmd_t    cmd,
	output logic                 busy
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DISP  = 3'd1;
	localparam logic [2:0] ST_CONV  = 3'd2;
	localparam logic [2:0] ST_SEEK  = 3'd3;
	localparam logic [2:0] ST_SIGN  = 3'd4;
	localparam logic [2:0] ST_DIG   = 3'd5;
	localparam logic [2:0] ST_SPEC  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.sel   = fse_pkg::SEL_PCT;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = ST_DISP;
				end
			end
			ST_DISP: begin
				case (status.kind)
					fse_pkg::KIND_CHAR: begin
						cmd.emit  = 1'b1;
						cmd.sel   = fse_pkg::SEL_ARG;
						cmd.last  = 1'b1;
						state_nxt = ST_IDLE;
					end
					fse_pkg::KIND_PCT: begin
						cmd.emit  = 1'b1;
						cmd.last  = 1'b1;
						state_nxt = ST_IDLE;
					end
					fse_pkg::KIND_DEC: begin
						state_nxt = ST_CONV;
					end
					default: begin
						cmd.emit  = 1'b1;
						state_nxt = ST_SPEC;
					end
				endcase
			end
			ST_SPEC: begin
				cmd.emit  = 1'b1;
				cmd.sel   = fse_pkg::SEL_MODE;
				cmd.last  = 1'b1;
				state_nxt = ST_IDLE;
			end
			ST_CONV: begin
				cmd.shift = 1'b1;
				if (status.conv_last) state_nxt = ST_SEEK;
			end
			ST_SEEK: begin
				cmd.seek  = 1'b1;
				state_nxt = status.neg ? ST_SIGN : ST_DIG;
			end
			ST_SIGN: begin
				cmd.emit  = 1'b1;
				cmd.sel   = fse_pkg::SEL_MINUS;
				state_nxt = ST_DIG;
			end
			ST_DIG: begin
				cmd.emit = 1'b1;
				cmd.sel  = fse_pkg::SEL_DIGIT;
				cmd.last = status.dig_last;
				if (status.dig_last) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule
